FILE: hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Word width of stored values and default stack depth.
  localparam int DATA_W            = 32;
  localparam int STACK_DEPTH_DEF   = 64;

  // Word reported for top and minimum when the stack is empty.
  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

  // Operation codes carried on in_tuser.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Error codes reported with each result.
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // an input word is taken this cycle
    logic fill;     // read data of a pop is loaded into the top registers
    logic load;     // the output registers capture a result
  } mts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } mts_status_t;

endpackage

FILE: hw/rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Controller: sequences push and pop operations and owns the output valid.
// ----------------------------------------------------------------------------
module mts_ctrl
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_op,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  mts_status_t status,
  output mts_cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   ready;
  logic   take;
  logic   pop_fetch;

  // Take a word only when idle and the output slot is free or being freed.
  assign ready     = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign take      = ready && in_tvalid;
  // A pop of a non-empty stack needs a memory read for the new top.
  assign pop_fetch = take && (in_op == OP_POP) && !status.empty;

  assign cmd.accept = take;
  assign cmd.fill   = (state_r == S_FILL);
  assign cmd.load   = (take && !pop_fetch) || (state_r == S_FILL);

  assign in_tready  = ready;
  assign out_tvalid = out_valid_r;

  // Next state and output valid.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (pop_fetch) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// Datapath: value and minimum memories, counts, cached tops, result registers.
// ----------------------------------------------------------------------------
module mts_datapath
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mts_cmd_t          cmd,
  input  logic              in_op,
  input  logic [DATA_W-1:0] in_value,
  output mts_status_t       status,
  output logic [DATA_W-1:0] top_value,
  output logic [DATA_W-1:0] min_value,
  output logic              is_empty,
  output logic [1:0]        error
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic [DATA_W-1:0] value_mem [STACK_DEPTH];
  logic [DATA_W-1:0] min_mem   [STACK_DEPTH];

  logic [CW-1:0]     value_count_r, value_count_nxt;
  logic [CW-1:0]     min_count_r,   min_count_nxt;
  logic [DATA_W-1:0] top_r,         top_nxt;
  logic [DATA_W-1:0] min_top_r,     min_top_nxt;
  logic              min_popped_r;
  logic [DATA_W-1:0] val_rd_r;
  logic [DATA_W-1:0] min_rd_r;

  logic [DATA_W-1:0] out_top_r, out_top_nxt;
  logic [DATA_W-1:0] out_min_r, out_min_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic [1:0]        out_err_r, out_err_nxt;

  logic              empty;
  logic              full;
  logic              do_push;
  logic              do_pop;
  logic              min_push;
  logic              min_pop;
  logic [CW-1:0]     val_rd_cnt;
  logic [CW-1:0]     min_rd_cnt;

  assign empty  = (value_count_r == '0);
  assign full   = (value_count_r == FULL_COUNT);
  assign status = '{empty: empty, full: full};

  assign do_push  = cmd.accept && (in_op == OP_PUSH) && !full;
  assign do_pop   = cmd.accept && (in_op == OP_POP) && !empty;
  // Equal values also go on the minimum stack so duplicates survive a pop.
  assign min_push = do_push &&
                    ((min_count_r == '0) || ($signed(in_value) <= $signed(min_top_r)));
  assign min_pop  = do_pop && (min_count_r != '0) && (top_r == min_top_r);

  // Addresses of the entries that become the new tops after a pop.
  assign val_rd_cnt = value_count_r - CW'(2);
  assign min_rd_cnt = min_count_r - CW'(2);

  // Counts and cached tops.
  always_comb begin
    value_count_nxt = value_count_r;
    min_count_nxt   = min_count_r;
    top_nxt         = top_r;
    min_top_nxt     = min_top_r;
    if (do_push) begin
      value_count_nxt = value_count_r + CW'(1);
      top_nxt         = in_value;
    end
    if (min_push) begin
      min_count_nxt = min_count_r + CW'(1);
      min_top_nxt   = in_value;
    end
    if (do_pop) begin
      value_count_nxt = value_count_r - CW'(1);
    end
    if (min_pop) begin
      min_count_nxt = min_count_r - CW'(1);
    end
    if (cmd.fill) begin
      top_nxt = val_rd_r;
      if (min_popped_r) begin
        min_top_nxt = min_rd_r;
      end
    end
  end

  // Result for the output registers.
  always_comb begin
    out_top_nxt   = out_top_r;
    out_min_nxt   = out_min_r;
    out_empty_nxt = out_empty_r;
    out_err_nxt   = out_err_r;
    if (cmd.fill) begin
      out_err_nxt = ERR_OK;
      if (value_count_r == '0) begin
        out_top_nxt   = EMPTY_WORD;
        out_min_nxt   = EMPTY_WORD;
        out_empty_nxt = 1'b1;
      end else begin
        out_top_nxt   = val_rd_r;
        out_min_nxt   = min_popped_r ? min_rd_r : min_top_r;
        out_empty_nxt = 1'b0;
      end
    end else if (in_op == OP_PUSH) begin
      out_empty_nxt = 1'b0;
      if (full) begin
        out_top_nxt = top_r;
        out_min_nxt = min_top_r;
        out_err_nxt = ERR_FULL;
      end else begin
        out_top_nxt = in_value;
        out_min_nxt = min_push ? in_value : min_top_r;
        out_err_nxt = ERR_OK;
      end
    end else begin
      // Pop on an empty stack is ignored.
      out_top_nxt   = EMPTY_WORD;
      out_min_nxt   = EMPTY_WORD;
      out_empty_nxt = 1'b1;
      out_err_nxt   = ERR_EMPTY;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_count_r <= '0;
      min_count_r   <= '0;
      min_popped_r  <= 1'b0;
    end else begin
      value_count_r <= value_count_nxt;
      min_count_r   <= min_count_nxt;
      if (cmd.accept) begin
        min_popped_r <= min_pop;
      end
    end
  end

  // Cached tops and result registers.
  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    min_top_r <= min_top_nxt;
    if (cmd.load) begin
      out_top_r   <= out_top_nxt;
      out_min_r   <= out_min_nxt;
      out_empty_r <= out_empty_nxt;
      out_err_r   <= out_err_nxt;
    end
  end

  // Value memory: written on push, read below the top on pop.
  always_ff @(posedge clk) begin
    if (do_push) begin
      value_mem[value_count_r[AW-1:0]] <= in_value;
    end
    if (do_pop) begin
      val_rd_r <= value_mem[val_rd_cnt[AW-1:0]];
    end
  end

  // Minimum memory: written on a new or equal minimum, read below the top on pop.
  always_ff @(posedge clk) begin
    if (min_push) begin
      min_mem[min_count_r[AW-1:0]] <= in_value;
    end
    if (do_pop) begin
      min_rd_r <= min_mem[min_rd_cnt[AW-1:0]];
    end
  end

  assign top_value = out_top_r;
  assign min_value = out_min_r;
  assign is_empty  = out_empty_r;
  assign error     = out_err_r;

endmodule

FILE: hw/rtl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Last-in first-out stack of signed words that also reports its minimum.
// ----------------------------------------------------------------------------
// Each input word is a push (in_tuser = 0, value in in_tdata) or a pop
// (in_tuser = 1) and yields exactly one output word showing the top value,
// the minimum of all held values (both all ones when empty), an empty flag
// and an error code (1 push on full, 2 pop on empty; such words change
// nothing). A push and any flagged word load the output register as they are
// taken. A pop of a non-empty stack loads it from a fill state, as the new top
// and minimum come out of the registered read port of the value and minimum
// memories. Outside the fill state a new input word is taken once the output
// register is empty, or in the cycle its result word is accepted downstream.
// The memories hold STACK_DEPTH words each and need no clearing after reset.
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] top_value, [63:32] min_value
  output logic [2:0]  out_tuser   // [0] is_empty, [2:1] error
);

  mts_cmd_t          cmd;
  mts_status_t       status;
  logic [DATA_W-1:0] top_value;
  logic [DATA_W-1:0] min_value;
  logic              is_empty;
  logic [1:0]        error;

  // Sequencing and handshake control.
  mts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Stacks, counts and result registers.
  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_tuser),
    .in_value  (in_tdata),
    .status    (status),
    .top_value (top_value),
    .min_value (min_value),
    .is_empty  (is_empty),
    .error     (error)
  );

  assign out_tdata = {min_value, top_value};
  assign out_tuser = {error, is_empty};

endmodule
